@@ rtl/wpwg_pkg.sv @@
// ----------------------------------------------------------------------------
// wpwg_pkg
// Shared widths, defaults and prime tables for the wheel-6 pre-sieve word
// generator.
// ----------------------------------------------------------------------------
package wpwg_pkg;

  // word channel payload widths
  localparam int IDX_W  = 32;
  localparam int MASK_W = 64;

  // defaults for the top-level parameters
  localparam int WORD_BITS_DEF  = 64;
  localparam int MAX_PRIMES_DEF = 16;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int PCNT_W     = 5;
  localparam logic [PCNT_W-1:0] PCNT_RESET = 5'd16;
  localparam int REG_PRIME_COUNT = 0;

  // residue arithmetic: final residues are below 64, raw ones below 128
  localparam int RES_W  = 6;
  localparam int RAW_W  = 7;
  localparam int X_W    = 12;
  localparam int GATE_W = 11;

  localparam int PRIME_LIST_LEN = 16;

  // the small primes applied by the pre-sieve
  localparam int PRIME_TBL [PRIME_LIST_LEN] = '{
    5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61
  };

  // bit index residue mod p that hits a multiple of p, for even bit index
  localparam int EVEN_TGT [PRIME_LIST_LEN] = '{
    0, 3, 2, 7, 4, 11, 6, 8, 19, 23, 12, 27, 14, 16, 18, 39
  };

  // same for odd bit index
  localparam int ODD_TGT [PRIME_LIST_LEN] = '{
    2, 1, 6, 3, 10, 5, 14, 18, 9, 11, 26, 13, 30, 34, 38, 19
  };

  // bit index of p*p: marking starts here
  localparam int GATE_TBL [PRIME_LIST_LEN] = '{
    7, 15, 39, 55, 95, 119, 175, 279, 319, 455, 559, 615, 735, 935, 1159, 1239
  };

endpackage

@@ rtl/wpwg_if.sv @@
// ----------------------------------------------------------------------------
// wpwg_if
// Valid/ready channels of the pre-sieve word generator: request word in,
// composite mask word out.
// ----------------------------------------------------------------------------

// request channel
interface wpwg_in_if import wpwg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] word_index;

  modport source (output valid, output word_index, input ready);
  modport sink   (input valid, input word_index, output ready);
endinterface

// result channel
interface wpwg_out_if import wpwg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  word_number;
  logic [MASK_W-1:0] composite_mask;

  modport source (output valid, output word_number, output composite_mask, input ready);
  modport sink   (input valid, input word_number, input composite_mask, output ready);
endinterface

@@ rtl/wheel_presieve_word_generator_top.sv @@
// ----------------------------------------------------------------------------
// wheel_presieve_word_generator_top
// Builds pre-sieve words for a bitmap over the numbers coprime to 6.
//
// word_in carries a word index; word_out returns that index as word_number
// together with composite_mask, where bit b is set when the number of bitmap
// bit word_index*WORD_BITS+b is a multiple n of one of the first prime_count
// primes p of 5..61 with n >= p*p. Mask bits at and above WORD_BITS are 0.
// prime_count sits at APB byte address 0; the user must write it only while
// no word is in flight (the block does not enforce it); pready is always high.
// One word is accepted per cycle when the receiver keeps up. A request is
// loaded into the first of seven register stages at the accept (two
// reciprocal-multiply residue steps, offset setup, lane match), and its
// result is valid once it reaches the last stage.
// When the receiver stalls, the stages still fill up bubble by bubble, so
// requests are taken until all seven stages hold a word; nothing is dropped
// or repeated. Reset empties the pipeline and sets prime_count to 16.
// ----------------------------------------------------------------------------
module wheel_presieve_word_generator_top import wpwg_pkg::*; #(
  parameter int WORD_BITS  = WORD_BITS_DEF,
  parameter int MAX_PRIMES = MAX_PRIMES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  wpwg_in_if.sink               word_in,
  wpwg_out_if.source            word_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int NS   = 7;
  localparam int BW   = IDX_W + $clog2(WORD_BITS);
  localparam int LW   = $clog2(WORD_BITS + 1);
  localparam int REGA = APB_ADDR_W - 2;

  // configuration register
  logic [PCNT_W-1:0] prime_count;
  logic [REGA-1:0]   reg_sel;

  assign reg_sel = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_count <= PCNT_RESET;
    end else if (psel && penable && pwrite && (reg_sel == REGA'(REG_PRIME_COUNT))) begin
      prime_count <= pwdata[PCNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REGA'(REG_PRIME_COUNT)) begin
      prdata = APB_DATA_W'(prime_count);
    end
  end

  // stage valids and per-stage advance
  logic [NS-1:0] vld;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !vld[NS-1] || word_out.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign word_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          vld[k] <= (k == 0) ? word_in.valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // word index and first bit index travel with the word
  logic [IDX_W-1:0] w_s1, w_s2, w_s3, w_s4, w_s5, w_s6;
  logic [BW-1:0]    base_s1, base_s2, base_s3, base_s4, base_s5;
  logic             par_s6;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      w_s1    <= word_in.word_index;
      base_s1 <= BW'(word_in.word_index) * BW'(WORD_BITS);
    end
    if (adv[1]) begin
      w_s2    <= w_s1;
      base_s2 <= base_s1;
    end
    if (adv[2]) begin
      w_s3    <= w_s2;
      base_s3 <= base_s2;
    end
    if (adv[3]) begin
      w_s4    <= w_s3;
      base_s4 <= base_s3;
    end
    if (adv[4]) begin
      w_s5    <= w_s4;
      base_s5 <= base_s4;
    end
    if (adv[5]) begin
      w_s6   <= w_s5;
      par_s6 <= base_s5[0];
    end
  end

  // per-prime match offsets and start limits, read by every lane
  logic [RES_W-1:0] d0_s6 [MAX_PRIMES];
  logic [RES_W-1:0] d1_s6 [MAX_PRIMES];
  logic [LW-1:0]    lo_s6 [MAX_PRIMES];

  for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_prime
    localparam int P   = PRIME_TBL[i];
    localparam int WBM = WORD_BITS % P;
    localparam int T0  = EVEN_TGT[i];
    localparam int T1  = ODD_TGT[i];
    localparam int G   = GATE_TBL[i];
    localparam longint unsigned M1 = (64'd1 << IDX_W) / P;
    localparam int M2  = (1 << 16) / P;

    logic [63:0]      prod1;
    logic [RAW_W-1:0] q1_s1;
    logic [RAW_W-1:0] raw2;
    logic [RES_W-1:0] wm_s2;
    logic [X_W-1:0]   x_s3, x_s4;
    logic [25:0]      prod2;
    logic [RAW_W-1:0] q2_s4;
    logic [RAW_W-1:0] raw5;
    logic [RES_W-1:0] a_s5;
    logic [RAW_W-1:0] e0, e1;
    logic [GATE_W-1:0] gap;
    logic [LW-1:0]     lo_next;

    // quotient estimate of w/p, low bits only: it is q or q-1
    assign prod1 = {{(64-IDX_W){1'b0}}, word_in.word_index} * 64'(M1);

    // remainder below 2p, one correction
    assign raw2 = w_s1[RAW_W-1:0] - RAW_W'(q1_s1 * RAW_W'(P));

    // quotient estimate of x/p for the rescaled residue
    assign prod2 = 26'(x_s3) * 26'(M2);
    assign raw5  = x_s4[RAW_W-1:0] - RAW_W'(q2_s4 * RAW_W'(P));

    // offsets of the hit residues from the base residue
    assign e0 = (RAW_W'(T0) >= RAW_W'(a_s5)) ? RAW_W'(T0) - RAW_W'(a_s5)
                                              : RAW_W'(T0) + RAW_W'(P) - RAW_W'(a_s5);
    assign e1 = (RAW_W'(T1) >= RAW_W'(a_s5)) ? RAW_W'(T1) - RAW_W'(a_s5)
                                              : RAW_W'(T1) + RAW_W'(P) - RAW_W'(a_s5);

    // first lane at or past p*p, clipped to the word length
    always_comb begin
      gap     = GATE_W'(G) - base_s5[GATE_W-1:0];
      lo_next = '0;
      if (base_s5 < BW'(G)) begin
        lo_next = (gap > GATE_W'(WORD_BITS)) ? LW'(WORD_BITS) : LW'(gap);
      end
    end

    always_ff @(posedge clk) begin
      if (adv[0]) begin
        q1_s1 <= prod1[IDX_W +: RAW_W];
      end
      if (adv[1]) begin
        wm_s2 <= (raw2 >= RAW_W'(P)) ? RES_W'(raw2 - RAW_W'(P)) : RES_W'(raw2);
      end
      if (adv[2]) begin
        x_s3 <= X_W'(wm_s2) * X_W'(WBM);
      end
      if (adv[3]) begin
        x_s4  <= x_s3;
        q2_s4 <= prod2[16 +: RAW_W];
      end
      if (adv[4]) begin
        a_s5 <= (raw5 >= RAW_W'(P)) ? RES_W'(raw5 - RAW_W'(P)) : RES_W'(raw5);
      end
      if (adv[5]) begin
        d0_s6[i] <= RES_W'(e0);
        d1_s6[i] <= RES_W'(e1);
        lo_s6[i] <= lo_next;
      end
    end
  end

  // lane match: bit b hits when its residue lands on the offset for its parity
  logic [WORD_BITS-1:0] lane_hit;

  for (genvar b = 0; b < WORD_BITS; b++) begin : g_lane
    logic [MAX_PRIMES-1:0] hit;
    for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_hit
      localparam int BM = b % PRIME_TBL[i];
      localparam bit BO = (b % 2) == 1;
      logic             odd;
      logic [RES_W-1:0] tgt;
      assign odd    = par_s6 ^ BO;
      assign tgt    = odd ? d1_s6[i] : d0_s6[i];
      assign hit[i] = (PCNT_W'(i) < prime_count) && (LW'(b) >= lo_s6[i]) &&
                      (tgt == RES_W'(BM));
    end
    assign lane_hit[b] = |hit;
  end

  // output register
  logic [IDX_W-1:0]  w_s7;
  logic [MASK_W-1:0] mask_s7;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      w_s7    <= w_s6;
      mask_s7 <= MASK_W'(lane_hit);
    end
  end

  assign word_out.valid          = vld[NS-1];
  assign word_out.word_number    = w_s7;
  assign word_out.composite_mask = mask_s7;

endmodule
